// ===== design/mtc_pkg.sv =====
// shared types and constants of the magnetometer trim compensation core
// no dependencies; used by every module of the core
package mtc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRIM_XY   = 3'd0,
        CFG_TRIM_Z1   = 3'd1,
        CFG_TRIM_Z2   = 3'd2,
        CFG_TRIM_Z3   = 3'd3,
        CFG_TRIM_Z4   = 3'd4,
        CFG_TRIM_XYZ1 = 3'd5
    } t_cfg_idx;

    localparam int CFG_DATA_W = 48;
    localparam int DIV_STEPS  = 32;   // quotient bits, one divider cell each
    localparam int DIV_W      = 17;   // divisor and remainder width

    localparam logic signed [12:0] XY_OVF_CODE = -13'sd4096;
    localparam logic signed [14:0] Z_OVF_CODE  = -15'sd16384;
    localparam logic signed [15:0] INVALID_OUT = -16'sd32768;
    localparam logic [15:0]        T_BIAS      = 16'h4000;
    localparam logic signed [25:0] A_BIAS      = 26'sh0100000;
    localparam logic signed [9:0]  GAIN_BIAS   = 10'sd160;
    localparam logic [31:0]        Z_ROUND     = 32'd32768;
    localparam logic [31:0]        Z_SAT_MAG   = 32'd32767;

    // trim words as unpacked from the configuration registers
    typedef struct packed {
        logic signed [7:0]  x1;
        logic signed [7:0]  y1;
        logic signed [7:0]  x2;
        logic signed [7:0]  y2;
        logic [7:0]         xy1;
        logic signed [7:0]  xy2;
        logic [15:0]        z1;
        logic signed [15:0] z2;
        logic signed [15:0] z3;
        logic signed [15:0] z4;
        logic [15:0]        xyz1;
    } t_trim;

    // one divider lane: remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [31:0]      dq;
        logic [DIV_W-1:0] dvs;
    } t_lane;

    // sample data riding along the divider chain
    typedef struct packed {
        logic signed [12:0] raw_x;
        logic signed [12:0] raw_y;
        logic               inv_x;
        logic               inv_y;
        logic               inv_z;
        logic               q_neg;
    } t_side;

    // one compensated result
    typedef struct packed {
        logic signed [15:0] comp_x;
        logic signed [15:0] comp_y;
        logic signed [15:0] comp_z;
    } t_result;

endpackage

// ===== design/mtc_sample_if.sv =====
// request channel carrying one raw magnetometer sample
// no dependencies
interface mtc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] raw_x;
    logic signed [12:0] raw_y;
    logic signed [14:0] raw_z;
    logic [13:0]        hall_resistance;

    modport source(output valid, output raw_x, output raw_y, output raw_z,
                   output hall_resistance, input ready);
    modport sink(input valid, input raw_x, input raw_y, input raw_z,
                 input hall_resistance, output ready);
endinterface

// ===== design/mtc_result_if.sv =====
// request channel carrying one compensated result
// no dependencies
interface mtc_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;

    modport source(output valid, output comp_x, output comp_y, output comp_z, input ready);
    modport sink(input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

// ===== design/mtc_front.sv =====
// front pipeline: validity checks, Z numerator and denominator, divider lane setup
// depends on mtc_pkg
module mtc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic signed [12:0]  i_raw_x,
    input  logic signed [12:0]  i_raw_y,
    input  logic signed [14:0]  i_raw_z,
    input  logic [13:0]         i_hall,
    input  mtc_pkg::t_trim      i_trim,
    output logic                o_valid,
    output mtc_pkg::t_side      o_side,
    output mtc_pkg::t_lane      o_lane_xy,
    output mtc_pkg::t_lane      o_lane_z
);

    // stage 0: sample register
    logic               r_v0;
    logic signed [12:0] r_x0, r_y0;
    logic signed [14:0] r_z0;
    logic [13:0]        r_h0;

    // stage 1: flags, offsets, z1 product
    logic               r_v1;
    logic signed [12:0] r_x1, r_y1;
    logic [13:0]        r_h1;
    logic [2:0]         r_inv1, n_inv1;
    logic signed [17:0] r_dz1, n_dz1;
    logic signed [17:0] r_dr1, n_dr1;
    logic [30:0]        r_pz1, n_pz1;

    // stage 2: slope product and denominator
    logic               r_v2;
    logic signed [12:0] r_x2, r_y2;
    logic [13:0]        r_h2;
    logic [2:0]         r_inv2;
    logic signed [17:0] r_dz2;
    logic signed [33:0] r_p2, n_p2;
    logic signed [17:0] r_den2, n_den2;

    // stage 3: signs and magnitudes into the divider lanes
    logic           r_v3;
    mtc_pkg::t_side r_side, n_side;
    mtc_pkg::t_lane r_lxy, n_lxy, r_lz, n_lz;

    logic               w_bad_common;
    logic [31:0]        w_rsum;
    logic signed [15:0] w_zterm;
    logic signed [33:0] w_num;
    logic [33:0]        w_num_mag;
    logic [17:0]        w_den_mag;

    // stage 1 logic
    always_comb begin
        w_bad_common = (r_h0 == '0) || (i_trim.xyz1 == '0);
        n_inv1[0] = (r_x0 == mtc_pkg::XY_OVF_CODE) || w_bad_common;
        n_inv1[1] = (r_y0 == mtc_pkg::XY_OVF_CODE) || w_bad_common;
        n_inv1[2] = (r_z0 == mtc_pkg::Z_OVF_CODE) || w_bad_common ||
                    (i_trim.z1 == '0) || (i_trim.z2 == '0);
        n_dz1 = 18'(r_z0) - 18'(i_trim.z4);
        n_dr1 = $signed({4'b0, r_h0}) - 18'($signed(i_trim.xyz1));
        n_pz1 = 31'(i_trim.z1) * 31'({r_h0, 1'b0});
    end

    // stage 2 logic
    always_comb begin
        n_p2    = 34'(i_trim.z3) * 34'(r_dr1);
        w_rsum  = {1'b0, r_pz1} + mtc_pkg::Z_ROUND;
        w_zterm = $signed(w_rsum[31:16]);
        n_den2  = 18'(i_trim.z2) + 18'(w_zterm);
    end

    // stage 3 logic
    always_comb begin
        w_num     = (34'(r_dz2) <<< 15) - (r_p2 >>> 2);
        w_num_mag = w_num[33] ? 34'(-w_num) : 34'(w_num);
        w_den_mag = r_den2[17] ? 18'(-r_den2) : 18'(r_den2);

        n_side.raw_x = r_x2;
        n_side.raw_y = r_y2;
        n_side.inv_x = r_inv2[0];
        n_side.inv_y = r_inv2[1];
        n_side.inv_z = r_inv2[2] || (r_den2 == '0);
        n_side.q_neg = w_num[33] ^ r_den2[17];

        n_lxy.rem = '0;
        n_lxy.dq  = {2'b00, i_trim.xyz1, 14'b0};
        n_lxy.dvs = {3'b000, r_h2};

        n_lz.rem = '0;
        n_lz.dq  = w_num_mag[31:0];
        n_lz.dvs = w_den_mag[16:0];
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ce) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x0   <= i_raw_x;
            r_y0   <= i_raw_y;
            r_z0   <= i_raw_z;
            r_h0   <= i_hall;
            r_x1   <= r_x0;
            r_y1   <= r_y0;
            r_h1   <= r_h0;
            r_inv1 <= n_inv1;
            r_dz1  <= n_dz1;
            r_dr1  <= n_dr1;
            r_pz1  <= n_pz1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_h2   <= r_h1;
            r_inv2 <= r_inv1;
            r_dz2  <= r_dz1;
            r_p2   <= n_p2;
            r_den2 <= n_den2;
            r_side <= n_side;
            r_lxy  <= n_lxy;
            r_lz   <= n_lz;
        end
    end

    assign o_valid   = r_v3;
    assign o_side    = r_side;
    assign o_lane_xy = r_lxy;
    assign o_lane_z  = r_lz;

endmodule

// ===== design/mtc_div_cell.sv =====
// one restoring-division cell: one quotient bit for the X/Y lane and the Z lane
// depends on mtc_pkg
module mtc_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  mtc_pkg::t_side i_side,
    input  mtc_pkg::t_lane i_lane_xy,
    input  mtc_pkg::t_lane i_lane_z,
    output logic           o_valid,
    output mtc_pkg::t_side o_side,
    output mtc_pkg::t_lane o_lane_xy,
    output mtc_pkg::t_lane o_lane_z
);

    logic           r_valid;
    mtc_pkg::t_side r_side;
    mtc_pkg::t_lane r_lxy, n_lxy, r_lz, n_lz;

    // shift in the next dividend bit, subtract when it fits
    function automatic mtc_pkg::t_lane div_step(mtc_pkg::t_lane l);
        mtc_pkg::t_lane       s;
        logic [mtc_pkg::DIV_W:0] sh;
        logic [mtc_pkg::DIV_W:0] df;
        logic                 fit;
        sh  = {l.rem, l.dq[31]};
        df  = sh - {1'b0, l.dvs};
        fit = (sh >= {1'b0, l.dvs});
        s.rem = fit ? df[mtc_pkg::DIV_W-1:0] : sh[mtc_pkg::DIV_W-1:0];
        s.dq  = {l.dq[30:0], fit};
        s.dvs = l.dvs;
        return s;
    endfunction

    always_comb begin
        n_lxy = div_step(i_lane_xy);
        n_lz  = div_step(i_lane_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side <= i_side;
            r_lxy  <= n_lxy;
            r_lz   <= n_lz;
        end
    end

    assign o_valid   = r_valid;
    assign o_side    = r_side;
    assign o_lane_xy = r_lxy;
    assign o_lane_z  = r_lz;

endmodule

// ===== design/mtc_back.sv =====
// back pipeline: Z sign and saturation, X/Y quadratic correction and offset
// depends on mtc_pkg
module mtc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_valid,
    input  mtc_pkg::t_side   i_side,
    input  logic [31:0]      i_q_xy,
    input  logic [31:0]      i_q_z,
    input  mtc_pkg::t_trim   i_trim,
    output logic             o_valid,
    output mtc_pkg::t_result o_res
);

    typedef struct packed {
        logic signed [12:0] raw_x;
        logic signed [12:0] raw_y;
        logic               inv_x;
        logic               inv_y;
        logic signed [15:0] comp_z;
    } t_carry;

    logic [6:0]       r_vb;
    t_carry           r_cy [0:5];
    t_carry           n_cy;

    logic signed [15:0] r_t, n_t;
    logic signed [31:0] r_tt, n_tt;
    logic signed [24:0] r_m1, n_m1, r_m2;
    logic signed [32:0] r_aq, n_aq;
    logic signed [33:0] w_sum;
    logic signed [25:0] r_a, n_a;
    logic signed [9:0]  w_gx, w_gy;
    logic signed [35:0] r_bx, n_bx, r_by, n_by;
    logic signed [23:0] w_ax, w_ay;
    logic signed [36:0] r_px, n_px, r_py, n_py;
    logic signed [15:0] w_cx, w_cy;
    mtc_pkg::t_result   r_res, n_res;
    logic [14:0]        w_zmag;
    logic signed [15:0] w_zs;

    // resistance term and Z sign with saturation
    always_comb begin
        n_t    = $signed(i_q_xy[15:0] - mtc_pkg::T_BIAS);
        w_zmag = (i_q_z > mtc_pkg::Z_SAT_MAG) ? 15'h7fff : i_q_z[14:0];
        w_zs   = i_side.q_neg ? -$signed({1'b0, w_zmag}) : $signed({1'b0, w_zmag});
        n_cy.raw_x  = i_side.raw_x;
        n_cy.raw_y  = i_side.raw_y;
        n_cy.inv_x  = i_side.inv_x;
        n_cy.inv_y  = i_side.inv_y;
        n_cy.comp_z = i_side.inv_z ? mtc_pkg::INVALID_OUT : w_zs;
    end

    // quadratic correction products
    always_comb begin
        n_tt = r_t * r_t;
        n_m1 = r_t * $signed({1'b0, i_trim.xy1});
        n_aq = 33'(i_trim.xy2) * 33'(r_tt >>> 7);
        w_sum = 34'(r_aq) + (34'(r_m2) <<< 7);
        n_a  = 26'($signed(w_sum[33:9])) + mtc_pkg::A_BIAS;
    end

    // per-axis gain, raw scaling and offset
    always_comb begin
        w_gx = 10'(i_trim.x2) + mtc_pkg::GAIN_BIAS;
        w_gy = 10'(i_trim.y2) + mtc_pkg::GAIN_BIAS;
        n_bx = 36'(r_a) * 36'(w_gx);
        n_by = 36'(r_a) * 36'(w_gy);
        w_ax = $signed(r_bx[35:12]);
        w_ay = $signed(r_by[35:12]);
        n_px = 37'(r_cy[4].raw_x) * 37'(w_ax);
        n_py = 37'(r_cy[4].raw_y) * 37'(w_ay);
        w_cx = $signed(r_px[28:13]) + $signed({i_trim.x1, 3'b000});
        w_cy = $signed(r_py[28:13]) + $signed({i_trim.y1, 3'b000});
        n_res.comp_x = r_cy[5].inv_x ? mtc_pkg::INVALID_OUT : w_cx;
        n_res.comp_y = r_cy[5].inv_y ? mtc_pkg::INVALID_OUT : w_cy;
        n_res.comp_z = r_cy[5].comp_z;
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (i_ce) begin
            r_vb <= {r_vb[5:0], i_valid};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cy[0] <= n_cy;
            for (int k = 1; k < 6; k++) begin
                r_cy[k] <= r_cy[k-1];
            end
            r_t   <= n_t;
            r_tt  <= n_tt;
            r_m1  <= n_m1;
            r_aq  <= n_aq;
            r_m2  <= r_m1;
            r_a   <= n_a;
            r_bx  <= n_bx;
            r_by  <= n_by;
            r_px  <= n_px;
            r_py  <= n_py;
            r_res <= n_res;
        end
    end

    assign o_valid = r_vb[6];
    assign o_res   = r_res;

endmodule

// ===== design/magnetometer_trim_compensation_core.sv =====
// top level of the magnetometer trim compensation core
// depends on mtc_pkg, mtc_sample_if, mtc_result_if, mtc_front, mtc_div_cell, mtc_back
//
// Takes one raw sample (X, Y, Z, hall resistance) per cycle unless stalled and
// returns one trim-compensated X/Y/Z result per sample, in order, through 4 front
// stages, a chain of 32 restoring-division cells (one quotient bit each, shared
// by the X/Y resistance divide and the Z divide) and 7 back stages. The pipeline
// stalls as a whole only when a second finished result piles up behind an untaken
// one in the two-entry output buffer. Invalid codes, a zero hall resistance, zero
// xyz1/z1/z2 trims or a zero Z divisor give -32768. The user writes trim registers
// through the plain write port while no sample is in flight; nothing enforces it.
module magnetometer_trim_compensation_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_index,
    input  logic [mtc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mtc_sample_if.sink                      i_sample,
    mtc_result_if.source                    o_result
);

    localparam int N = mtc_pkg::DIV_STEPS;

    logic [47:0] r_trim_xy;
    logic [15:0] r_z1, r_z2, r_z3, r_z4, r_xyz1;
    mtc_pkg::t_trim w_trim;

    logic           w_ce;
    logic           w_cv   [0:N];
    mtc_pkg::t_side w_side [0:N];
    mtc_pkg::t_lane w_lxy  [0:N];
    mtc_pkg::t_lane w_lz   [0:N];

    logic             w_last_v;
    mtc_pkg::t_result w_last_res;
    logic             r_o_v, r_sk_v;
    mtc_pkg::t_result r_o_res, r_sk_res;
    logic             w_push, w_pop;

    // trim registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_xy <= '0;
            r_z1      <= '0;
            r_z2      <= '0;
            r_z3      <= '0;
            r_z4      <= '0;
            r_xyz1    <= '0;
        end else if (i_cfg_wr_en) begin
            case (mtc_pkg::t_cfg_idx'(i_cfg_index))
                mtc_pkg::CFG_TRIM_XY:   r_trim_xy <= i_cfg_data;
                mtc_pkg::CFG_TRIM_Z1:   r_z1      <= i_cfg_data[15:0];
                mtc_pkg::CFG_TRIM_Z2:   r_z2      <= i_cfg_data[15:0];
                mtc_pkg::CFG_TRIM_Z3:   r_z3      <= i_cfg_data[15:0];
                mtc_pkg::CFG_TRIM_Z4:   r_z4      <= i_cfg_data[15:0];
                mtc_pkg::CFG_TRIM_XYZ1: r_xyz1    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // unpack trim words
    always_comb begin
        w_trim.x1   = $signed(r_trim_xy[7:0]);
        w_trim.y1   = $signed(r_trim_xy[15:8]);
        w_trim.x2   = $signed(r_trim_xy[23:16]);
        w_trim.y2   = $signed(r_trim_xy[31:24]);
        w_trim.xy1  = r_trim_xy[39:32];
        w_trim.xy2  = $signed(r_trim_xy[47:40]);
        w_trim.z1   = r_z1;
        w_trim.z2   = $signed(r_z2);
        w_trim.z3   = $signed(r_z3);
        w_trim.z4   = $signed(r_z4);
        w_trim.xyz1 = r_xyz1;
    end

    // pipeline advances unless the output buffer is full
    assign w_ce           = !r_sk_v;
    assign i_sample.ready = w_ce;

    mtc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (w_ce),
        .i_valid   (i_sample.valid),
        .i_raw_x   (i_sample.raw_x),
        .i_raw_y   (i_sample.raw_y),
        .i_raw_z   (i_sample.raw_z),
        .i_hall    (i_sample.hall_resistance),
        .i_trim    (w_trim),
        .o_valid   (w_cv[0]),
        .o_side    (w_side[0]),
        .o_lane_xy (w_lxy[0]),
        .o_lane_z  (w_lz[0])
    );

    // divider chain
    for (genvar g = 0; g < N; g++) begin : g_div
        mtc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ce      (w_ce),
            .i_valid   (w_cv[g]),
            .i_side    (w_side[g]),
            .i_lane_xy (w_lxy[g]),
            .i_lane_z  (w_lz[g]),
            .o_valid   (w_cv[g+1]),
            .o_side    (w_side[g+1]),
            .o_lane_xy (w_lxy[g+1]),
            .o_lane_z  (w_lz[g+1])
        );
    end

    mtc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_cv[N]),
        .i_side  (w_side[N]),
        .i_q_xy  (w_lxy[N].dq),
        .i_q_z   (w_lz[N].dq),
        .i_trim  (w_trim),
        .o_valid (w_last_v),
        .o_res   (w_last_res)
    );

    // two-entry output buffer
    assign w_push = w_ce && w_last_v;
    assign w_pop  = r_o_v && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (w_pop) begin
                r_sk_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_o_v || w_pop) begin
                r_o_v <= 1'b1;
            end else begin
                r_sk_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (w_pop) begin
                r_o_res <= r_sk_res;
            end
        end else if (w_push) begin
            if (!r_o_v || w_pop) begin
                r_o_res <= w_last_res;
            end else begin
                r_sk_res <= w_last_res;
            end
        end
    end

    assign o_result.valid  = r_o_v;
    assign o_result.comp_x = r_o_res.comp_x;
    assign o_result.comp_y = r_o_res.comp_y;
    assign o_result.comp_z = r_o_res.comp_z;

endmodule

// ===== tb/tb_trim_scoreboard.sv =====
`timescale 1ns / 1ps
// scoreboard for the magnetometer trim compensation core: predicts results from the trim words
// depends on mtc_pkg
class trim_scoreboard;
    mtc_pkg::t_trim    trim;
    mtc_pkg::t_result  pending_results[$];
    int                failures;

    function new();
        trim = '0;
        failures = 0;
    endfunction

    // register write, mirrors the core's configuration port
    function void write_trim(mtc_pkg::t_cfg_idx idx, logic [47:0] data);
        case (idx)
            mtc_pkg::CFG_TRIM_XY: begin
                trim.x1  = data[7:0];
                trim.y1  = data[15:8];
                trim.x2  = data[23:16];
                trim.y2  = data[31:24];
                trim.xy1 = data[39:32];
                trim.xy2 = data[47:40];
            end
            mtc_pkg::CFG_TRIM_Z1:   trim.z1 = data[15:0];
            mtc_pkg::CFG_TRIM_Z2:   trim.z2 = data[15:0];
            mtc_pkg::CFG_TRIM_Z3:   trim.z3 = data[15:0];
            mtc_pkg::CFG_TRIM_Z4:   trim.z4 = data[15:0];
            mtc_pkg::CFG_TRIM_XYZ1: trim.xyz1 = data[15:0];
            default: ;
        endcase
    endfunction

    // arithmetic shift rounds toward minus infinity
    function longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function logic signed [15:0] compensate_xy(longint raw, longint r, longint off,
                                                longint gain);
        longint xyz1, xy1, xy2, t, q, a;
        logic signed [15:0] w;
        xyz1 = longint'(trim.xyz1);
        xy1  = longint'(trim.xy1);
        xy2  = longint'(trim.xy2);
        if (raw == longint'(mtc_pkg::XY_OVF_CODE) || r == 0 || xyz1 == 0)
            return mtc_pkg::INVALID_OUT;
        q = (xyz1 * 16384) / r;
        w = 16'((q & 64'hFFFF) - 16'h4000);
        t = longint'(w);
        a = xy2 * floor_shift(t * t, 7) + t * (xy1 * 128);
        a = floor_shift(a, 9) + 64'h100000;
        a = floor_shift(a * (gain + 160), 12);
        w = 16'(floor_shift(raw * a, 13));
        a = longint'(w);
        w = 16'(a + off * 8);
        return w;
    endfunction

    function logic signed [15:0] compensate_z(longint raw, longint r);
        longint z1, z2, z3, z4, xyz1s, num, den, v;
        logic signed [15:0] w;
        z1 = longint'(trim.z1);
        z2 = longint'(trim.z2);
        z3 = longint'(trim.z3);
        z4 = longint'(trim.z4);
        xyz1s = longint'($signed(trim.xyz1));
        if (raw == longint'(mtc_pkg::Z_OVF_CODE) || z2 == 0 || z1 == 0 || r == 0 ||
            trim.xyz1 == 0)
            return mtc_pkg::INVALID_OUT;
        num = (raw - z4) * 32768 - floor_shift(z3 * (r - xyz1s), 2);
        w = 16'(floor_shift(z1 * (r * 2) + 32768, 16));
        den = z2 + longint'(w);
        if (den == 0) return mtc_pkg::INVALID_OUT;
        v = num / den;
        if (v > 32767) v = 32767;
        else if (v < -32767) v = -32767;
        return 16'(v);
    endfunction

    // accepted sample: queue its expected result
    function void note_sample(logic signed [12:0] x, logic signed [12:0] y,
                              logic signed [14:0] z, logic [13:0] r);
        mtc_pkg::t_result res;
        res.comp_x = compensate_xy(longint'(x), longint'(r), longint'(trim.x1),
                                   longint'(trim.x2));
        res.comp_y = compensate_xy(longint'(y), longint'(r), longint'(trim.y1),
                                   longint'(trim.y2));
        res.comp_z = compensate_z(longint'(z), longint'(r));
        pending_results.push_back(res);
    endfunction

    function void check_result(mtc_pkg::t_result got);
        mtc_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("unexpected result x=%0d y=%0d z=%0d", got.comp_x, got.comp_y, got.comp_z);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        if (got.comp_x !== want.comp_x) begin
            $error("comp_x expected %0d actual %0d", want.comp_x, got.comp_x);
            failures++;
        end
        if (got.comp_y !== want.comp_y) begin
            $error("comp_y expected %0d actual %0d", want.comp_y, got.comp_y);
            failures++;
        end
        if (got.comp_z !== want.comp_z) begin
            $error("comp_z expected %0d actual %0d", want.comp_z, got.comp_z);
            failures++;
        end
    endfunction
endclass

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top of magnetometer_trim_compensation_core: directed and random samples
// depends on mtc_pkg, mtc_sample_if, mtc_result_if, tb_trim_scoreboard and the core
module tb;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_wr_en = 0;
    logic [2:0]    i_cfg_index = '0;
    logic [47:0]   i_cfg_data = '0;
    longint        cycle_count = 0;
    trim_scoreboard sb = new();

    mtc_sample_if sample_ch();
    mtc_result_if result_ch();

    magnetometer_trim_compensation_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_ch.sink),
        .o_result    (result_ch.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        sample_ch.valid = 0;
        sample_ch.raw_x = '0;
        sample_ch.raw_y = '0;
        sample_ch.raw_z = '0;
        sample_ch.hall_resistance = '0;
        result_ch.ready = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("magnetometer_trim_compensation_core regression: fail");
            $finish;
        end
    end

    // result sink with random stalls; sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{result_ch.comp_x, result_ch.comp_y, result_ch.comp_z});
    end

    initial begin : result_stall
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                result_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1;
            @(posedge i_clk iff result_ch.valid);
        end
    end

    // one register write; the enable drops before the next write can start
    task automatic write_reg(mtc_pkg::t_cfg_idx idx, logic [47:0] data);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_trim(idx, data);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    // 16-bit trim word write
    task automatic write_word(mtc_pkg::t_cfg_idx idx, logic [15:0] data);
        write_reg(idx, {32'h0, data});
    endtask

    // one sample request, waits for acceptance; burst mode skips idle gaps
    task automatic send_sample(logic signed [12:0] x, logic signed [12:0] y,
                               logic signed [14:0] z, logic [13:0] r, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            sample_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1;
        sample_ch.raw_x <= x;
        sample_ch.raw_y <= y;
        sample_ch.raw_z <= z;
        sample_ch.hall_resistance <= r;
        @(posedge i_clk iff sample_ch.ready);
        sb.note_sample(x, y, z, r);
    endtask

    task automatic drain();
        sample_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_trims(bit extreme);
        if (extreme) begin
            write_reg(mtc_pkg::CFG_TRIM_XY,
                      ($urandom_range(0, 1) != 0) ? 48'hFFFF_FFFF_FFFF : 48'h807F_8080_7F7F);
            write_word(mtc_pkg::CFG_TRIM_Z1, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001);
            write_word(mtc_pkg::CFG_TRIM_Z2, ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000);
            write_word(mtc_pkg::CFG_TRIM_Z3, ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000);
            write_word(mtc_pkg::CFG_TRIM_Z4, ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000);
            write_word(mtc_pkg::CFG_TRIM_XYZ1,
                       ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001);
        end else begin
            write_reg(mtc_pkg::CFG_TRIM_XY, 48'({$urandom(), $urandom()}));
            write_word(mtc_pkg::CFG_TRIM_Z1,
                       ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom()));
            write_word(mtc_pkg::CFG_TRIM_Z2,
                       ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom()));
            write_word(mtc_pkg::CFG_TRIM_Z3, 16'($urandom()));
            write_word(mtc_pkg::CFG_TRIM_Z4, 16'($urandom()));
            write_word(mtc_pkg::CFG_TRIM_XYZ1,
                       ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom()));
        end
    endtask

    task automatic random_sample();
        logic signed [12:0] x, y;
        logic signed [14:0] z;
        logic [13:0]        r;
        x = 13'($urandom());
        y = 13'($urandom());
        z = 15'($urandom());
        r = 14'($urandom());
        if ($urandom_range(0, 19) == 0) x = mtc_pkg::XY_OVF_CODE;
        if ($urandom_range(0, 19) == 0) y = mtc_pkg::XY_OVF_CODE;
        if ($urandom_range(0, 19) == 0) z = mtc_pkg::Z_OVF_CODE;
        if ($urandom_range(0, 29) == 0) r = 14'd0;
        send_sample(x, y, z, r, $urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset trims: everything invalid
        send_sample(13'sd100, -13'sd100, 15'sd500, 14'd6000, 1'b0);
        drain();

        // typical trims
        write_reg(mtc_pkg::CFG_TRIM_XY, 48'h04_1D_00_00_00_00);
        write_word(mtc_pkg::CFG_TRIM_Z1, 16'd23000);
        write_word(mtc_pkg::CFG_TRIM_Z2, 16'd700);
        write_word(mtc_pkg::CFG_TRIM_Z3, 16'd0);
        write_word(mtc_pkg::CFG_TRIM_Z4, 16'd0);
        write_word(mtc_pkg::CFG_TRIM_XYZ1, 16'd6500);
        send_sample(13'sd4095, 13'sd4095, 15'sd16383, 14'd16383, 1'b0);
        send_sample(-13'sd4095, -13'sd4095, -15'sd16383, 14'd1, 1'b0);
        send_sample(mtc_pkg::XY_OVF_CODE, 13'sd0, 15'sd0, 14'd6500, 1'b0);
        send_sample(13'sd0, mtc_pkg::XY_OVF_CODE, mtc_pkg::Z_OVF_CODE, 14'd6500, 1'b0);
        send_sample(13'sd1000, -13'sd1000, 15'sd2000, 14'd0, 1'b0);
        send_sample(13'sd1, -13'sd1, 15'sd1, 14'd6500, 1'b1);
        drain();

        // z divisor exactly zero: z2 cancels resistance term (r=2, z1=32768 -> 2)
        write_word(mtc_pkg::CFG_TRIM_Z1, 16'h8000);
        write_word(mtc_pkg::CFG_TRIM_Z2, -16'sd2);
        send_sample(13'sd10, 13'sd10, 15'sd10, 14'd2, 1'b0);
        drain();
        // saturation both ways with a tiny divisor
        write_word(mtc_pkg::CFG_TRIM_Z2, -16'sd1);
        send_sample(13'sd10, 13'sd10, 15'sd16383, 14'd2, 1'b0);
        send_sample(13'sd10, 13'sd10, -15'sd16383, 14'd2, 1'b0);
        drain();

        // zero z1, zero z2, zero xyz1
        write_word(mtc_pkg::CFG_TRIM_Z1, 16'h0);
        send_sample(13'sd50, 13'sd50, 15'sd50, 14'd100, 1'b0);
        drain();
        write_word(mtc_pkg::CFG_TRIM_Z1, 16'd100);
        write_word(mtc_pkg::CFG_TRIM_Z2, 16'h0);
        send_sample(13'sd50, 13'sd50, 15'sd50, 14'd100, 1'b0);
        drain();
        write_word(mtc_pkg::CFG_TRIM_Z2, 16'd100);
        write_word(mtc_pkg::CFG_TRIM_XYZ1, 16'h0);
        send_sample(13'sd50, 13'sd50, 15'sd50, 14'd100, 1'b0);
        drain();

        // extreme then random trim sets, with random samples
        for (int phase = 0; phase < 10; phase++) begin
            random_trims(phase < 3);
            for (int n = 0; n < 80; n++) random_sample();
            drain();
        end

        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("magnetometer_trim_compensation_core regression: pass");
        else
            $display("magnetometer_trim_compensation_core regression: fail");
        $finish;
    end
endmodule
